[hw/rtl/efp_pkg.sv]
// Shared constants for the 8.3 filename parser.
package efp_pkg;

  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 4;

  localparam logic [CfgIdxW-1:0] CFG_DEFAULT_DRIVE = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_WILDCARD_MODE = 1'd1;

  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_P = 8'h50;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_Z = 8'h7A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CASE_OFS = 8'h20;
  localparam logic [7:0] LOW_MASK = 8'h7F;

  localparam logic [5:0] ANY_DRIVE = 6'd63;

endpackage

[hw/rtl/efp_parse.sv]
// Per-character parse state: drive prefix, name and extension buffers.
module efp_parse import efp_pkg::*; #(
  parameter int NAME_LEN = 8,
  parameter int EXT_LEN = 3,
  localparam int Total = 1 + NAME_LEN + EXT_LEN
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    fire_i,
  input  logic [7:0]              ch_i,
  input  logic                    eon_i,
  input  logic [3:0]              default_drive_i,
  input  logic                    wildcard_i,
  output logic [Total-1:0][6:0]   vals_o,
  output logic                    err_o
);

  localparam int NfW = $clog2(NAME_LEN + 1);
  localparam int EfW = $clog2(EXT_LEN + 1);

  localparam logic [1:0] POS_FIRST = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_BODY = 2'd2;

  typedef struct packed {
    logic [NAME_LEN-1:0][6:0] run;
    logic [NAME_LEN-1:0][6:0] dot;
    logic [EXT_LEN-1:0][6:0]  ext;
    logic [NfW-1:0]           nfill;
    logic [EfW-1:0]           efill;
    logic                     nstar;
    logic                     estar;
    logic                     dotf;
  } body_t;

  localparam body_t BodyRst = '{
    run:   {NAME_LEN{CH_SPACE[6:0]}},
    dot:   {NAME_LEN{CH_SPACE[6:0]}},
    ext:   {EXT_LEN{CH_SPACE[6:0]}},
    nfill: '0,
    efill: '0,
    nstar: 1'b0,
    estar: 1'b0,
    dotf:  1'b0
  };

  function automatic logic [6:0] fold(logic [7:0] c);
    logic [7:0] u;
    u = (c >= CH_LO_A && c <= CH_LO_Z) ? c - CASE_OFS : c;
    return u[6:0] & LOW_MASK[6:0];
  endfunction

  function automatic body_t body_step(body_t b, logic [7:0] c);
    body_t r;
    logic [6:0] f;
    r = b;
    f = fold(c);
    if (c == CH_DOT) begin
      r.dot = b.run;
      r.ext = {EXT_LEN{CH_SPACE[6:0]}};
      r.efill = '0;
      r.estar = 1'b0;
      r.dotf = 1'b1;
    end
    if (!b.nstar && b.nfill < NfW'(NAME_LEN)) begin
      if (c == CH_STAR) begin
        for (int k = 0; k < NAME_LEN; k++) begin
          if (NfW'(k) >= b.nfill) r.run[k] = CH_QUEST[6:0];
        end
        r.nfill = NfW'(NAME_LEN);
        r.nstar = 1'b1;
      end else begin
        for (int k = 0; k < NAME_LEN; k++) begin
          if (NfW'(k) == b.nfill) r.run[k] = f;
        end
        r.nfill = b.nfill + 1'b1;
      end
    end
    if (c != CH_DOT && b.dotf && !b.estar && b.efill < EfW'(EXT_LEN)) begin
      if (c == CH_STAR) begin
        for (int k = 0; k < EXT_LEN; k++) begin
          if (EfW'(k) >= b.efill) r.ext[k] = CH_QUEST[6:0];
        end
        r.efill = EfW'(EXT_LEN);
        r.estar = 1'b1;
      end else begin
        for (int k = 0; k < EXT_LEN; k++) begin
          if (EfW'(k) == b.efill) r.ext[k] = f;
        end
        r.efill = b.efill + 1'b1;
      end
    end
    return r;
  endfunction

  body_t      body_q, body_d;
  logic [1:0] pos_q, pos_d;
  logic [7:0] first_q, first_d;
  logic [5:0] drv_q, drv_d;
  logic       given_q, given_d;
  logic       err_q, err_d;

  body_t      b_first, b_two, b_one, fin;
  logic [7:0] first_up;
  logic       empty;

  always_comb begin
    b_first = body_step(body_q, first_q);
    b_two = body_step(b_first, ch_i);
    b_one = body_step(body_q, ch_i);
    first_up = (first_q >= CH_LO_A && first_q <= CH_LO_Z) ? first_q - CASE_OFS : first_q;

    body_d = body_q;
    pos_d = pos_q;
    first_d = first_q;
    drv_d = drv_q;
    given_d = given_q;
    err_d = err_q;

    if (fire_i) begin
      if (eon_i) begin
        body_d = BodyRst;
        pos_d = POS_FIRST;
        first_d = '0;
        drv_d = '0;
        given_d = 1'b0;
        err_d = 1'b0;
      end else begin
        case (pos_q)
          POS_FIRST: begin
            if (ch_i == CH_COLON) err_d = 1'b1;
            first_d = ch_i;
            pos_d = POS_SECOND;
          end
          POS_SECOND: begin
            if (ch_i == CH_COLON) begin
              if (first_up == CH_QUEST || first_up == CH_STAR) begin
                drv_d = ANY_DRIVE;
              end else if (first_up >= CH_UP_A && first_up <= CH_UP_P) begin
                drv_d = 6'(first_up - CH_UP_A);
              end else begin
                err_d = 1'b1;
              end
              given_d = 1'b1;
            end else begin
              body_d = b_two;
            end
            pos_d = POS_BODY;
          end
          default: begin
            if (ch_i == CH_COLON && !given_q) begin
              err_d = 1'b1;
            end else begin
              body_d = b_one;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_q <= BodyRst;
      pos_q <= POS_FIRST;
      first_q <= '0;
      drv_q <= '0;
      given_q <= 1'b0;
      err_q <= 1'b0;
    end else begin
      body_q <= body_d;
      pos_q <= pos_d;
      first_q <= first_d;
      drv_q <= drv_d;
      given_q <= given_d;
      err_q <= err_d;
    end
  end

  always_comb begin
    fin = (pos_q == POS_SECOND) ? b_first : body_q;
    empty = !fin.dotf && fin.nfill == '0 && !fin.nstar;
    if (given_q) begin
      vals_o[0] = {1'b0, drv_q};
    end else if (wildcard_i) begin
      vals_o[0] = {1'b0, ANY_DRIVE};
    end else begin
      vals_o[0] = {3'b000, default_drive_i};
    end
    for (int k = 0; k < NAME_LEN; k++) begin
      if (wildcard_i && empty) begin
        vals_o[1 + k] = CH_QUEST[6:0];
      end else begin
        vals_o[1 + k] = fin.dotf ? fin.dot[k] : fin.run[k];
      end
    end
    for (int k = 0; k < EXT_LEN; k++) begin
      if (fin.dotf) begin
        vals_o[1 + NAME_LEN + k] = fin.ext[k];
      end else begin
        vals_o[1 + NAME_LEN + k] = wildcard_i ? CH_QUEST[6:0] : CH_SPACE[6:0];
      end
    end
  end

  assign err_o = err_q;

endmodule

[hw/rtl/efp_emit.sv]
// Result buffer that replays one parsed filename slot by slot.
module efp_emit #(
  parameter int NAME_LEN = 8,
  parameter int EXT_LEN = 3,
  localparam int Total = 1 + NAME_LEN + EXT_LEN,
  localparam int SlotW = $clog2(Total)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic [Total-1:0][6:0] vals_i,
  input  logic                  err_i,
  output logic                  free_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [SlotW-1:0]      slot_o,
  output logic [6:0]            value_o,
  output logic                  bad_o,
  output logic                  last_o
);

  logic [Total-1:0][6:0] vals_q;
  logic                  err_q;
  logic                  busy_q;
  logic [SlotW-1:0]      idx_q;
  logic                  beat;

  assign beat = busy_q && ready_i;
  assign last_o = err_q || idx_q == SlotW'(Total - 1);
  assign free_o = !busy_q || (beat && last_o);
  assign valid_o = busy_q;
  assign slot_o = idx_q;
  assign value_o = err_q ? 7'd0 : vals_q[idx_q];
  assign bad_o = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q <= '0;
      err_q <= 1'b0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q <= '0;
      err_q <= err_i;
    end else if (beat) begin
      if (last_o) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) vals_q <= vals_i;
  end

endmodule

[hw/rtl/eight_three_filename_parser.sv]
// Top level of the 8.3 filename parser: configuration, stream ports and glue.
//
// Characters stream in one per transfer, and only a terminator can be stalled. The
// terminator hands the parsed name to an output buffer that sends
// 1 + NAME_LEN + EXT_LEN result transfers (12 by default), or one error result,
// at one per cycle while m_axis_tready is high. Characters of the next filename are
// taken while that buffer drains; only the next terminator waits until the buffer is
// sending its final result or is empty, so back-to-back runs of fewer than 12
// characters are paced by the output buffer.
module eight_three_filename_parser import efp_pkg::*; #(
  parameter int NAME_LEN = 8,
  parameter int EXT_LEN = 3,
  localparam int Total = 1 + NAME_LEN + EXT_LEN,
  localparam int SlotW = $clog2(Total),
  localparam int OutW = ((SlotW + 7 + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // ch
  input  logic                s_axis_tlast,  // end_of_name
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutW-1:0]     m_axis_tdata,  // slot, value, zero fill
  output logic                m_axis_tuser,  // bad_syntax
  output logic                m_axis_tlast,  // last
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [3:0]            default_drive_q;
  logic                  wildcard_q;
  logic                  fire;
  logic                  free;
  logic [Total-1:0][6:0] vals;
  logic                  err;
  logic [SlotW-1:0]      slot;
  logic [6:0]            value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_drive_q <= '0;
      wildcard_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEFAULT_DRIVE: default_drive_q <= cfg_data_i[3:0];
        CFG_WILDCARD_MODE: wildcard_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !s_axis_tlast || free;
  assign fire = s_axis_tvalid && s_axis_tready;

  efp_parse #(
    .NAME_LEN(NAME_LEN),
    .EXT_LEN (EXT_LEN)
  ) u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .ch_i           (s_axis_tdata),
    .eon_i          (s_axis_tlast),
    .default_drive_i(default_drive_q),
    .wildcard_i     (wildcard_q),
    .vals_o         (vals),
    .err_o          (err)
  );

  efp_emit #(
    .NAME_LEN(NAME_LEN),
    .EXT_LEN (EXT_LEN)
  ) u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire && s_axis_tlast),
    .vals_i (vals),
    .err_i  (err),
    .free_o (free),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .slot_o (slot),
    .value_o(value),
    .bad_o  (m_axis_tuser),
    .last_o (m_axis_tlast)
  );

  assign m_axis_tdata = OutW'({value, slot});

endmodule

[hw/rtl/efp_checker.sv]
// Port-level assertions for the 8.3 filename parser and their bind.
module efp_checker #(
  parameter int NAME_LEN = 8,
  parameter int EXT_LEN = 3,
  localparam int Total = 1 + NAME_LEN + EXT_LEN,
  localparam int SlotW = $clog2(Total),
  localparam int OutW = ((SlotW + 7 + 7) / 8) * 8
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tready,
  input logic            s_axis_tlast,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata,
  input logic            m_axis_tuser,
  input logic            m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled result changed.");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == '0)
    else $error("Error result is not a lone zero transfer.");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("Result run broke off before its last transfer.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s_axis_tlast && m_axis_tvalid)
    else $error("Input stalled without a pending terminator.");

endmodule

bind eight_three_filename_parser efp_checker #(
  .NAME_LEN(NAME_LEN),
  .EXT_LEN (EXT_LEN)
) u_efp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

[test/tb_eight_three_filename_parser.sv]
// Self-checking testbench for the 8.3 filename parser with a built-in prediction of each entry.
`timescale 1ns / 1ps

module tb_eight_three_filename_parser;
  import efp_pkg::*;

  localparam int NAME_LEN = 8;
  localparam int EXT_LEN = 3;
  localparam int SLOT_W = 4;
  localparam int VALUE_W = 7;
  localparam int OUT_W = 16;
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [NAME_LEN-1:0][6:0] name_buf_t;
  typedef logic [EXT_LEN-1:0][6:0] ext_buf_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
    logic               bad;
    logic               last;
  } dir_byte_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;  // ch
  logic                s_axis_tlast = 1'b0;  // end_of_name
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;  // slot, value, zero fill
  logic                m_axis_tuser;  // bad_syntax
  logic                m_axis_tlast;  // last
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  eight_three_filename_parser u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  dir_byte_t dir_entry_q[$];
  int        err_count = 0;
  int        items_sent = 0;
  int        cycle_count = 0;
  int        src_idle_pct = 0;
  int        sink_idle_pct = 0;

  logic [3:0] cfg_drive;
  logic       cfg_wild;
  name_buf_t  run_name;
  name_buf_t  dot_name;
  ext_buf_t   ext_buf;
  int         name_cnt;
  int         ext_cnt;
  logic       name_star;
  logic       ext_star;
  logic       seen_dot;
  int         char_pos;
  logic [7:0] held_char;
  logic [5:0] drive_sel;
  logic       has_prefix;
  logic       bad_run;

  function automatic logic [6:0] fold_char(input logic [7:0] c);
    logic [7:0] u;
    u = (c >= CH_LO_A && c <= CH_LO_Z) ? c - CASE_OFS : c;
    u = u & LOW_MASK;
    return u[6:0];
  endfunction

  task automatic clear_run();
    run_name = {NAME_LEN{CH_SPACE[6:0]}};
    dot_name = {NAME_LEN{CH_SPACE[6:0]}};
    ext_buf = {EXT_LEN{CH_SPACE[6:0]}};
    name_cnt = 0;
    ext_cnt = 0;
    name_star = 1'b0;
    ext_star = 1'b0;
    seen_dot = 1'b0;
    char_pos = 0;
    held_char = '0;
    drive_sel = '0;
    has_prefix = 1'b0;
    bad_run = 1'b0;
  endtask

  task automatic push_entry(input logic [SLOT_W-1:0] slot, input logic [VALUE_W-1:0] value,
                            input logic bad, input logic last);
    dir_byte_t e;
    e.slot = slot;
    e.value = value;
    e.bad = bad;
    e.last = last;
    dir_entry_q.push_back(e);
  endtask

  // The last dot snapshots the name; a star fills the rest of its part with question marks.
  task automatic take_body_char(input logic [7:0] c);
    if (c == CH_DOT) begin
      dot_name = run_name;
      ext_buf = {EXT_LEN{CH_SPACE[6:0]}};
      ext_cnt = 0;
      ext_star = 1'b0;
      seen_dot = 1'b1;
    end
    if (!name_star && name_cnt < NAME_LEN) begin
      if (c == CH_STAR) begin
        while (name_cnt < NAME_LEN) begin
          run_name[name_cnt] = CH_QUEST[6:0];
          name_cnt++;
        end
        name_star = 1'b1;
      end else begin
        run_name[name_cnt] = fold_char(c);
        name_cnt++;
      end
    end
    if (c != CH_DOT && seen_dot && !ext_star && ext_cnt < EXT_LEN) begin
      if (c == CH_STAR) begin
        while (ext_cnt < EXT_LEN) begin
          ext_buf[ext_cnt] = CH_QUEST[6:0];
          ext_cnt++;
        end
        ext_star = 1'b1;
      end else begin
        ext_buf[ext_cnt] = fold_char(c);
        ext_cnt++;
      end
    end
  endtask

  task automatic predict_entry(input logic [7:0] ch, input logic eon);
    logic [7:0] up;
    logic [5:0] drive;
    logic       blank;
    logic [6:0] v;
    if (!eon) begin
      if (char_pos == 0) begin
        if (ch == CH_COLON) bad_run = 1'b1;
        held_char = ch;
        char_pos = 1;
      end else if (char_pos == 1) begin
        if (ch == CH_COLON) begin
          up = (held_char >= CH_LO_A && held_char <= CH_LO_Z) ? held_char - CASE_OFS : held_char;
          if (up == CH_QUEST || up == CH_STAR) begin
            drive_sel = ANY_DRIVE;
          end else if (up >= CH_UP_A && up <= CH_UP_P) begin
            up = up - CH_UP_A;
            drive_sel = up[5:0];
          end else begin
            bad_run = 1'b1;
          end
          has_prefix = 1'b1;
        end else begin
          take_body_char(held_char);
          take_body_char(ch);
        end
        char_pos = 2;
      end else if (ch == CH_COLON && !has_prefix) begin
        bad_run = 1'b1;
      end else begin
        take_body_char(ch);
      end
    end else begin
      if (char_pos == 1) take_body_char(held_char);
      if (bad_run) begin
        push_entry('0, '0, 1'b1, 1'b1);
      end else begin
        drive = has_prefix ? drive_sel : (cfg_wild ? ANY_DRIVE : {2'b00, cfg_drive});
        push_entry('0, {1'b0, drive}, 1'b0, 1'b0);
        blank = !seen_dot && name_cnt == 0 && !name_star;
        for (int k = 0; k < NAME_LEN; k++) begin
          if (cfg_wild && blank) v = CH_QUEST[6:0];
          else v = seen_dot ? dot_name[k] : run_name[k];
          push_entry(SLOT_W'(k + 1), v, 1'b0, 1'b0);
        end
        for (int k = 0; k < EXT_LEN; k++) begin
          if (seen_dot) v = ext_buf[k];
          else v = cfg_wild ? CH_QUEST[6:0] : CH_SPACE[6:0];
          push_entry(SLOT_W'(1 + NAME_LEN + k), v, 1'b0, k == EXT_LEN - 1);
        end
      end
      clear_run();
    end
  endtask

  task automatic send_item(input logic [7:0] ch, input logic eon);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = ch;
    s_axis_tlast = eon;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_entry(ch, eon);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (dir_entry_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_DEFAULT_DRIVE) cfg_drive = data;
    else if (idx == CFG_WILDCARD_MODE) cfg_wild = data[0];
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 30) return CH_UP_A + 8'($urandom_range(25));
    if (r < 55) return CH_LO_A + 8'($urandom_range(25));
    if (r < 65) return 8'h30 + 8'($urandom_range(9));
    if (r < 72) return CH_STAR;
    if (r < 80) return CH_DOT;
    if (r < 83) return CH_COLON;
    if (r < 90) return CH_QUEST;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_random_name();
    int         d;
    logic [7:0] c;
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(14)) send_item(8'($urandom_range(255)), 1'b0);
    end else begin
      if ($urandom_range(99) < 35) begin
        d = $urandom_range(99);
        if (d < 40) c = CH_UP_A + 8'($urandom_range(15));
        else if (d < 70) c = CH_LO_A + 8'($urandom_range(15));
        else if (d < 80) c = CH_QUEST;
        else if (d < 90) c = CH_STAR;
        else c = 8'($urandom_range(255));
        send_item(c, 1'b0);
        send_item(CH_COLON, 1'b0);
      end
      repeat ($urandom_range(10)) send_item(pick_char(), 1'b0);
      if ($urandom_range(99) < 70) begin
        send_item(CH_DOT, 1'b0);
        repeat ($urandom_range(5)) send_item(pick_char(), 1'b0);
      end
    end
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic test_special_cases();
    send_text("");
    send_text("a:x.y");
    send_text(":");
    send_text("Q:");
    send_text("ab:");
    send_text("z");
    send_item(CH_STAR, 1'b0);
    send_item(CH_DOT, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_random_names(input int n_items);
    int start;
    start = items_sent;
    while (items_sent - start < n_items) send_random_name();
  endtask

  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin : check_results
    dir_byte_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (dir_entry_q.size() == 0) begin
        $error("unexpected result transfer: tdata %0h", m_axis_tdata);
        err_count++;
      end else begin
        e = dir_entry_q.pop_front();
        if (m_axis_tdata[SLOT_W-1:0] !== e.slot) begin
          $error("slot: expected %0d, got %0d", e.slot, m_axis_tdata[SLOT_W-1:0]);
          err_count++;
        end
        if (m_axis_tdata[SLOT_W+VALUE_W-1:SLOT_W] !== e.value) begin
          $error("value: expected %0h, got %0h", e.value, m_axis_tdata[SLOT_W+VALUE_W-1:SLOT_W]);
          err_count++;
        end
        if (m_axis_tuser !== e.bad) begin
          $error("bad_syntax: expected %0d, got %0d", e.bad, m_axis_tuser);
          err_count++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, m_axis_tlast);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[eight_three_filename_parser] ERROR");
      $finish;
    end
  end

  initial begin
    cfg_drive = '0;
    cfg_wild = 1'b0;
    clear_run();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    src_idle_pct = 9;
    sink_idle_pct = 72;
    write_reg(CFG_DEFAULT_DRIVE, 4'd0);
    write_reg(CFG_WILDCARD_MODE, 4'd0);
    test_special_cases();
    wait_idle();
    write_reg(CFG_DEFAULT_DRIVE, 4'd15);
    test_random_names(110);

    wait_idle();
    src_idle_pct = 72;
    sink_idle_pct = 9;
    write_reg(CFG_DEFAULT_DRIVE, 4'd0);
    write_reg(CFG_WILDCARD_MODE, 4'd1);
    test_random_names(110);

    wait_idle();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    write_reg(CFG_DEFAULT_DRIVE, 4'($urandom_range(15)));
    write_reg(CFG_WILDCARD_MODE, 4'd0);
    test_random_names(110);

    wait_idle();
    if (err_count == 0 && dir_entry_q.size() == 0) begin
      $display("[eight_three_filename_parser] OK");
    end else begin
      $display("[eight_three_filename_parser] ERROR");
    end
    $finish;
  end

endmodule
